FILE: design/mbc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the memoized binomial coefficient block.
// No dependencies; used by the interfaces, controller, datapath and top level.
package mbc_pkg;

	localparam int N_W    = 6;   // width of top_n and choose_k
	localparam int COEF_W = 31;  // width of a coefficient and of a store entry

	// datapath operation issued by the controller in a cycle
	typedef enum logic [1:0] {
		OP_IDLE,
		OP_FILL_COL,  // fill entry (r, j) while widening: left neighbor from store
		OP_FILL_ROW,  // fill entry (r, j) while adding rows: upper neighbor from store
		OP_READ       // read entry (r, j) for the answer
	} op_t;

	// source of the result coefficient
	typedef enum logic [1:0] {
		SEL_ZERO,  // range error
		SEL_ONE,   // folded k of zero
		SEL_RAM    // entry read from the store
	} sel_t;

	typedef struct packed {
		op_t  op;
		logic load;  // capture the result into the output register
		sel_t sel;
	} cmd_t;

endpackage

FILE: design/mbc_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying the indices n and k.
// Depends on mbc_pkg for the field widths.
interface mbc_req_if;
	logic                     valid;
	logic                     ready;
	logic [mbc_pkg::N_W-1:0]  top_n;
	logic [mbc_pkg::N_W-1:0]  choose_k;

	modport source (output valid, output top_n, output choose_k, input ready);
	modport sink (input valid, input top_n, input choose_k, output ready);
endinterface

FILE: design/mbc_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: valid/ready handshake carrying the coefficient and error flag.
// Depends on mbc_pkg for the field widths.
interface mbc_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [mbc_pkg::COEF_W-1:0] coefficient;
	logic                       range_error;

	modport source (output valid, output coefficient, output range_error, input ready);
	modport sink (input valid, input coefficient, input range_error, output ready);
endinterface

FILE: design/memoized_binomial_coefficient.sv
`timescale 1ns / 1ps
// Memoized binomial coefficient C(n,k) from a Pascal-triangle store that grows on demand.
// Requests with k > n or n > MAX_N answer 0 with range_error set; a folded k of 0
// answers 1. Other requests first widen the store to n-1 columns and add rows up
// to the folded k, filling one entry per cycle through the single read port of
// the store and one 31-bit adder, then read the entry through the same port. The
// worst case fills (MAX_N-1)*(MAX_N/2) entries (496 at MAX_N = 32). Requests that
// hit entries already filled fill no new ones. There is no clearing pass after reset.
// One request is worked on at a time; a new request is taken while the previous
// result still waits in the output register.
module memoized_binomial_coefficient #(
	parameter int MAX_N = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	mbc_req_if.sink    req,
	mbc_rsp_if.source  rsp
);

	localparam int RW = $clog2(MAX_N / 2 + 1);
	localparam int CW = $clog2(MAX_N);

	mbc_pkg::cmd_t  cmd;
	logic [RW-1:0]  r;
	logic [CW-1:0]  j;

	mbc_ctrl #(
		.MAX_N(MAX_N)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.top_n    (req.top_n),
		.choose_k (req.choose_k),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.cmd      (cmd),
		.r        (r),
		.j        (j)
	);

	mbc_dpath #(
		.MAX_N(MAX_N)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.r          (r),
		.j          (j),
		.coefficient(rsp.coefficient),
		.range_error(rsp.range_error)
	);

	// no new request while the store is being filled or read
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op != mbc_pkg::OP_IDLE |-> !req.ready)
		else $error("request accepted while datapath busy");

	// a result load never overwrites one still waiting
	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!rsp.valid || rsp.ready))
		else $error("result register overwritten");

	// row adding never starts at the first row
	a_row_fill_index: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == mbc_pkg::OP_FILL_ROW |-> r != '0)
		else $error("row fill at first row");

	// an error result always carries a zero coefficient
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.range_error |-> rsp.coefficient == '0)
		else $error("range error with nonzero coefficient");

endmodule

FILE: design/mbc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mbc_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 544
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/mbc_dpath.sv
`timescale 1ns / 1ps
// Datapath: triangle store, fill adder with its one-stage pipeline, result register.
// Depends on mbc_pkg and mbc_ram; driven by mbc_ctrl through cmd, r and j.
module mbc_dpath #(
	parameter int MAX_N = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mbc_pkg::cmd_t                        cmd,
	input  logic [$clog2(MAX_N / 2 + 1)-1:0]     r,
	input  logic [$clog2(MAX_N)-1:0]             j,
	output logic [mbc_pkg::COEF_W-1:0]           coefficient,
	output logic                                 range_error
);

	localparam int ROW_CAP = MAX_N / 2 + 1;
	localparam int COL_CAP = MAX_N;
	localparam int DEPTH   = ROW_CAP * COL_CAP;
	localparam int AW      = $clog2(DEPTH);
	localparam int RW      = $clog2(ROW_CAP);
	localparam int CW      = $clog2(COL_CAP);

	function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] row,
		input logic [CW-1:0] col);
		return AW'(int'(row) * COL_CAP + int'(col));
	endfunction

	logic                        fill;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [mbc_pkg::COEF_W-1:0]  rd_data;
	logic                        fill_s1;
	logic [RW-1:0]               r_s1;
	logic [CW-1:0]               j_s1;
	logic [mbc_pkg::COEF_W-1:0]  fill_val;
	logic [mbc_pkg::COEF_W-1:0]  last_q;
	logic [mbc_pkg::COEF_W-1:0]  coef_q;
	logic                        err_q;

	assign fill = (cmd.op == mbc_pkg::OP_FILL_COL) || (cmd.op == mbc_pkg::OP_FILL_ROW);

	// edge entries are closed forms; only interior entries fetch a neighbor
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_of(r, j);
		case (cmd.op)
			mbc_pkg::OP_FILL_COL: begin
				rd_en   = (r != '0) && (j != '0);
				rd_addr = addr_of(r, CW'(j - 1'b1));
			end
			mbc_pkg::OP_FILL_ROW: begin
				rd_en   = (r != '0) && (j != '0);
				rd_addr = addr_of(RW'(r - 1'b1), j);
			end
			mbc_pkg::OP_READ: begin
				rd_en   = 1'b1;
				rd_addr = addr_of(r, j);
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = addr_of(r, j);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_s1 <= 1'b0;
		end else begin
			fill_s1 <= fill;
		end
	end

	always_ff @(posedge clk) begin
		r_s1 <= r;
		j_s1 <= j;
	end

	// the other neighbor is always the entry filled just before this one
	always_comb begin
		if (r_s1 == '0) begin
			fill_val = mbc_pkg::COEF_W'(j_s1) + mbc_pkg::COEF_W'(2);
		end else if (j_s1 == '0) begin
			fill_val = mbc_pkg::COEF_W'(r_s1) + mbc_pkg::COEF_W'(2);
		end else begin
			fill_val = rd_data + last_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fill_s1) begin
			last_q <= fill_val;
		end
	end

	mbc_ram #(
		.WIDTH(mbc_pkg::COEF_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (fill_s1),
		.waddr(addr_of(r_s1, j_s1)),
		.wdata(fill_val),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (cmd.sel)
				mbc_pkg::SEL_ZERO: begin
					coef_q <= '0;
					err_q  <= 1'b1;
				end
				mbc_pkg::SEL_ONE: begin
					coef_q <= mbc_pkg::COEF_W'(1);
					err_q  <= 1'b0;
				end
				default: begin
					coef_q <= rd_data;
					err_q  <= 1'b0;
				end
			endcase
		end
	end

	assign coefficient = coef_q;
	assign range_error = err_q;

endmodule

FILE: design/mbc_ctrl.sv
`timescale 1ns / 1ps
// Controller: request decode, fill sequencing over the triangle, result handshake.
// Depends on mbc_pkg; drives mbc_dpath through cmd, r and j.
module mbc_ctrl #(
	parameter int MAX_N = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mbc_pkg::N_W-1:0]           top_n,
	input  logic [mbc_pkg::N_W-1:0]           choose_k,
	output logic                              out_valid,
	input  logic                              out_ready,
	output mbc_pkg::cmd_t                     cmd,
	output logic [$clog2(MAX_N / 2 + 1)-1:0]  r,
	output logic [$clog2(MAX_N)-1:0]          j
);

	localparam int ROW_CAP = MAX_N / 2 + 1;
	localparam int COL_CAP = MAX_N;
	localparam int RW      = $clog2(ROW_CAP);
	localparam int CW      = $clog2(COL_CAP);
	localparam int NW      = mbc_pkg::N_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PLAN   = 3'd1;
	localparam logic [2:0] ST_WIDEN  = 3'd2;
	localparam logic [2:0] ST_ROWS   = 3'd3;
	localparam logic [2:0] ST_READ   = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]    state_q;
	logic [NW-1:0] n_q;
	logic [RW-1:0] kf_q;
	logic          err_q;
	logic          triv_q;
	logic [CW-1:0] fw_q;
	logic [RW-1:0] fr_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] j_q;
	logic          out_valid_q;

	logic          accept;
	logic          err_in;
	logic [NW-1:0] diff_in;
	logic [NW-1:0] kf_in;
	logic          slot_free;
	logic          load;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign err_in    = (choose_k > top_n) || ((NW + 1)'(top_n) > (NW + 1)'(MAX_N));
	assign diff_in   = top_n - choose_k;
	assign kf_in     = (diff_in < choose_k) ? diff_in : choose_k;
	assign slot_free = !out_valid_q || out_ready;
	assign load      = (state_q == ST_FINISH) && slot_free;

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q    <= top_n;
			kf_q   <= RW'(kf_in);
			err_q  <= err_in;
			triv_q <= (kf_in == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fw_q        <= '0;
			fr_q        <= RW'(1);
			r_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PLAN;
					end
				end
				ST_PLAN: begin
					if (err_q || triv_q) begin
						state_q <= ST_FINISH;
					end else if ((NW + 1)'(n_q) > (NW + 1)'(fw_q) + (NW + 1)'(1)) begin
						r_q     <= '0;
						j_q     <= fw_q;
						state_q <= ST_WIDEN;
					end else if (kf_q > fr_q) begin
						r_q     <= fr_q;
						j_q     <= '0;
						state_q <= ST_ROWS;
					end else begin
						r_q     <= RW'(kf_q - 1'b1);
						j_q     <= CW'(n_q - NW'(kf_q) - NW'(1));
						state_q <= ST_READ;
					end
				end
				ST_WIDEN: begin
					// column by column, every existing row
					if (r_q == RW'(fr_q - 1'b1)) begin
						r_q <= '0;
						if ((NW + 1)'(j_q) == (NW + 1)'(n_q) - (NW + 1)'(2)) begin
							fw_q    <= CW'(n_q - NW'(1));
							state_q <= ST_PLAN;
						end else begin
							j_q <= CW'(j_q + 1'b1);
						end
					end else begin
						r_q <= RW'(r_q + 1'b1);
					end
				end
				ST_ROWS: begin
					// row by row, across the filled width
					if (j_q == CW'(fw_q - 1'b1)) begin
						j_q <= '0;
						if (r_q == RW'(kf_q - 1'b1)) begin
							fr_q    <= kf_q;
							state_q <= ST_PLAN;
						end else begin
							r_q <= RW'(r_q + 1'b1);
						end
					end else begin
						j_q <= CW'(j_q + 1'b1);
					end
				end
				ST_READ: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.op   = mbc_pkg::OP_IDLE;
		cmd.load = load;
		if (err_q) begin
			cmd.sel = mbc_pkg::SEL_ZERO;
		end else if (triv_q) begin
			cmd.sel = mbc_pkg::SEL_ONE;
		end else begin
			cmd.sel = mbc_pkg::SEL_RAM;
		end
		case (state_q)
			ST_WIDEN: cmd.op = mbc_pkg::OP_FILL_COL;
			ST_ROWS:  cmd.op = mbc_pkg::OP_FILL_ROW;
			ST_READ:  cmd.op = mbc_pkg::OP_READ;
			default:  cmd.op = mbc_pkg::OP_IDLE;
		endcase
	end

	assign r         = r_q;
	assign j         = j_q;
	assign out_valid = out_valid_q;

endmodule
